[hw/rtl/drag_fall_euler_step_unit_macros.svh]
// Assertion macros for the drag fall Euler step unit.
// Included by the top level; it relies on clk_i and rst_ni being in scope.
`ifndef DRAG_FALL_EULER_STEP_UNIT_MACROS_SVH
`define DRAG_FALL_EULER_STEP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFE_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/dfe_pkg.sv]
// Shared types, register indexes and helpers of the drag fall Euler step unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dfe_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_MASS      = 3'd0;
  localparam logic [2:0] REG_GRAVITY   = 3'd1;
  localparam logic [2:0] REG_DRAG_COEF = 3'd2;
  localparam logic [2:0] REG_TIME_STEP = 3'd3;
  localparam logic [2:0] REG_WIND_X    = 3'd4;
  localparam logic [2:0] REG_WIND_Y    = 3'd5;
  localparam logic [2:0] REG_WIND_Z    = 3'd6;

  // Request codes.
  localparam logic [1:0] REQ_LOAD      = 2'd0;
  localparam logic [1:0] REQ_STEP      = 2'd1;
  localparam logic [1:0] REQ_STEP_WIND = 2'd2;

  // Operation of the shared iterative unit.
  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_e;

  // Launch request towards the iterative unit.
  typedef struct packed {
    logic        start;
    iter_op_e    op;
    logic [63:0] x;
    logic [30:0] m;
  } iter_req_t;

  // Magnitude of a signed 32 bit value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (32'd0 - v) : v;
    return r;
  endfunction

endpackage

[hw/rtl/drag_fall_euler_step_unit.sv]
// Drag fall Euler step unit: point mass state, sequencer and output register.
// Uses the shared multiplier and the iterative unit.
// Channels: the input channel takes a request item (load, step, step with wind)
// on in_valid_i with in_stall_o low; the output channel shows the full state
// and a saturation flag on out_valid_o, held while out_stall_i is high.
// Configuration writes use cfg_valid_i and cfg_ready_o (always high) with a
// register index and data; write only while the block is idle.
// Load items and unknown codes go straight to S_OUT and into the output
// register. A step item runs fourteen products on the shared multiplier, a
// square root and three divisions by mass on the shared bit serial unit
// (launch, one bit per cycle, hand back), then goes into the output register.
// A division whose quotient overflows is clamped without the bit steps.
// The sequencer returns to idle as the result is registered, so the next item
// can be taken while the result is shown.
// One item is in work at a time; in_stall_o is high until it is finished.
// The result sits in an output register, so a new item can be taken while a
// result waits; a finished item waits for that register if it is still full.
// Reset clears the state to zero and the configuration registers to their defaults.
`timescale 1ns / 1ps

`include "drag_fall_euler_step_unit_macros.svh"

module drag_fall_euler_step_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] load_pos_x_i,
  input  logic signed [31:0] load_pos_y_i,
  input  logic signed [31:0] load_pos_z_i,
  input  logic signed [31:0] load_vel_x_i,
  input  logic signed [31:0] load_vel_y_i,
  input  logic signed [31:0] load_vel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic signed [31:0] acc_x_o,
  output logic signed [31:0] acc_y_o,
  output logic signed [31:0] acc_z_o,
  output logic               saturated_o
);
  import dfe_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_DRAG  = 4'd3;
  localparam logic [3:0] S_FORCE = 4'd4;
  localparam logic [3:0] S_MG    = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_POS   = 4'd7;
  localparam logic [3:0] S_VEL   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

  // Configuration registers.
  logic [30:0]        mass_q, gravity_q, drag_q, dt_q;
  logic signed [31:0] wind_q [3];

  // Architectural state and working registers.
  logic [3:0]         state_q;
  logic [1:0]         idx_q;
  logic               ph_q;
  logic               wind_en_q;
  logic               sat_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] acc_q [3];
  logic [63:0]        ss_q;
  logic [31:0]        norm_q;
  logic [30:0]        k_q;
  logic signed [48:0] force_q [3];

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] out_pos_q [3];
  logic signed [31:0] out_vel_q [3];
  logic signed [31:0] out_acc_q [3];
  logic               out_sat_q;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [47:0]        prod_hi;
  iter_req_t          iter_req;
  logic               iter_done;
  logic [31:0]        iter_res;

  logic signed [31:0] vel_sel, acc_sel;
  logic signed [48:0] force_sel;
  logic [47:0]        force_mag;
  logic signed [49:0] term, pos_sum, vel_sum, upd_sum;
  logic signed [31:0] upd_clip;
  logic               upd_ovf;
  logic signed [31:0] acc_new;
  logic               acc_ovf;
  logic               accept, cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;

  assign vel_sel   = vel_q[idx_q];
  assign acc_sel   = acc_q[idx_q];
  assign force_sel = force_q[idx_q];
  assign force_mag = force_sel[48] ? 48'(-force_sel) : force_sel[47:0];
  assign prod_hi   = prod[63:16];

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_q)
      S_SQ: begin
        mul_a = mag32(vel_sel);
        mul_b = mag32(vel_sel);
      end
      S_DRAG: begin
        mul_a = {1'b0, drag_q};
        mul_b = norm_q;
      end
      S_FORCE: begin
        mul_a = {1'b0, k_q};
        mul_b = mag32(vel_sel);
      end
      S_MG: begin
        mul_a = {1'b0, mass_q};
        mul_b = {1'b0, gravity_q};
      end
      S_POS: begin
        mul_a = mag32(vel_sel);
        mul_b = {1'b0, dt_q};
      end
      S_VEL: begin
        mul_a = mag32(acc_sel);
        mul_b = {1'b0, dt_q};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  dfe_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Launch of the square root or a division by mass.
  always_comb begin
    iter_req.start = !ph_q && (state_q == S_SQRT || state_q == S_DIV);
    iter_req.op    = (state_q == S_SQRT) ? OP_SQRT : OP_DIV;
    iter_req.x     = (state_q == S_SQRT) ? ss_q : {force_mag, 16'h0000};
    iter_req.m     = (mass_q == 31'd0) ? 31'd1 : mass_q;
  end

  dfe_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .done_o (iter_done),
    .res_o  (iter_res)
  );

  // Position and velocity updates with one saturation each.
  always_comb begin
    term    = (mul_a == mag32(vel_sel) && state_q == S_POS) ?
              (vel_sel[31] ? -$signed({2'b00, prod_hi}) : $signed({2'b00, prod_hi})) :
              (acc_sel[31] ? -$signed({2'b00, prod_hi}) : $signed({2'b00, prod_hi}));
    pos_sum = 50'(pos_q[idx_q]) + term + (wind_en_q ? 50'(wind_q[idx_q]) : 50'sd0);
    vel_sum = 50'(vel_sel) + term;
    upd_sum = (state_q == S_POS) ? pos_sum : vel_sum;
    upd_ovf = (upd_sum > S32_MAX) || (upd_sum < S32_MIN);
    if (upd_sum > S32_MAX) begin
      upd_clip = 32'sh7FFFFFFF;
    end else if (upd_sum < S32_MIN) begin
      upd_clip = 32'sh80000000;
    end else begin
      upd_clip = upd_sum[31:0];
    end
  end

  // Signed acceleration from the clamped quotient.
  always_comb begin
    acc_ovf = 1'b0;
    if (force_sel[48]) begin
      acc_new = -$signed(iter_res);
    end else if (iter_res[31]) begin
      acc_new = 32'sh7FFFFFFF;
      acc_ovf = 1'b1;
    end else begin
      acc_new = iter_res;
    end
  end

  // Configuration, sequencer and state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= 31'd65536;
      gravity_q   <= 31'd642252;
      drag_q      <= 31'd0;
      dt_q        <= 31'd655;
      wind_q      <= '{default: '0};
      state_q     <= S_IDLE;
      idx_q       <= 2'd0;
      ph_q        <= 1'b0;
      wind_en_q   <= 1'b0;
      sat_q       <= 1'b0;
      pos_q       <= '{default: '0};
      vel_q       <= '{default: '0};
      acc_q       <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_MASS:      mass_q    <= cfg_data_i[30:0];
          REG_GRAVITY:   gravity_q <= cfg_data_i[30:0];
          REG_DRAG_COEF: drag_q    <= cfg_data_i[30:0];
          REG_TIME_STEP: dt_q      <= cfg_data_i[30:0];
          REG_WIND_X:    wind_q[0] <= cfg_data_i;
          REG_WIND_Y:    wind_q[1] <= cfg_data_i;
          REG_WIND_Z:    wind_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      // The output register empties when its item leaves, unless refilled below.
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            sat_q     <= 1'b0;
            idx_q     <= 2'd0;
            ph_q      <= 1'b0;
            ss_q      <= 64'd0;
            wind_en_q <= (req_type_i == REQ_STEP_WIND);
            if (req_type_i == REQ_LOAD) begin
              pos_q[0] <= load_pos_x_i;
              pos_q[1] <= load_pos_y_i;
              pos_q[2] <= load_pos_z_i;
              vel_q[0] <= load_vel_x_i;
              vel_q[1] <= load_vel_y_i;
              vel_q[2] <= load_vel_z_i;
              state_q  <= S_OUT;
            end else if (req_type_i == REQ_STEP || req_type_i == REQ_STEP_WIND) begin
              state_q <= S_SQ;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_SQ: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            ss_q <= ss_q + prod;
            if (idx_q == 2'd2) begin
              idx_q   <= 2'd0;
              state_q <= S_SQRT;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_SQRT: begin
          if (ph_q && iter_done) begin
            norm_q  <= iter_res;
            ph_q    <= 1'b0;
            state_q <= S_DRAG;
          end else begin
            ph_q <= 1'b1;
          end
        end
        S_DRAG: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (prod[63:47] != 17'd0) begin
              k_q   <= 31'h7FFFFFFF;
              sat_q <= 1'b1;
            end else begin
              k_q <= prod[46:16];
            end
            state_q <= S_FORCE;
          end
        end
        S_FORCE: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            force_q[idx_q] <= vel_sel[31] ? $signed({1'b0, prod_hi})
                                          : -$signed({1'b0, prod_hi});
            if (idx_q == 2'd2) begin
              idx_q   <= 2'd0;
              state_q <= S_MG;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_MG: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            force_q[2] <= force_q[2] - $signed({1'b0, prod_hi});
            state_q    <= S_DIV;
          end
        end
        S_DIV: begin
          if (ph_q && iter_done) begin
            acc_q[idx_q] <= acc_new;
            if (acc_ovf) begin
              sat_q <= 1'b1;
            end
            ph_q <= 1'b0;
            if (idx_q == 2'd2) begin
              idx_q   <= 2'd0;
              state_q <= S_POS;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end else begin
            ph_q <= 1'b1;
          end
        end
        S_POS: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            pos_q[idx_q] <= upd_clip;
            if (upd_ovf) begin
              sat_q <= 1'b1;
            end
            if (idx_q == 2'd2) begin
              idx_q   <= 2'd0;
              state_q <= S_VEL;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_VEL: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            vel_q[idx_q] <= upd_clip;
            if (upd_ovf) begin
              sat_q <= 1'b1;
            end
            if (idx_q == 2'd2) begin
              idx_q   <= 2'd0;
              state_q <= S_OUT;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_pos_q   <= pos_q;
            out_vel_q   <= vel_q;
            out_acc_q   <= acc_q;
            out_sat_q   <= sat_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_pos_q[0];
  assign pos_y_o     = out_pos_q[1];
  assign pos_z_o     = out_pos_q[2];
  assign vel_x_o     = out_vel_q[0];
  assign vel_y_o     = out_vel_q[1];
  assign vel_z_o     = out_vel_q[2];
  assign acc_x_o     = out_acc_q[0];
  assign acc_y_o     = out_acc_q[1];
  assign acc_z_o     = out_acc_q[2];
  assign saturated_o = out_sat_q;

  // The iterative unit only reports back while the sequencer waits for it.
  `DFE_ASSERT_SAME(a_iter_done_waited, iter_done,
    ph_q && (state_q == S_SQRT || state_q == S_DIV), "iterative result unexpected")
  // A taken item always puts the sequencer to work.
  `DFE_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "item taken but idle")
  // The output register is only refilled once the previous result has left.
  `DFE_ASSERT_NEXT(a_out_no_overwrite, out_valid_q && out_stall_i,
    out_valid_q && $stable(out_pos_q[0]) && $stable(out_sat_q), "result overwritten")

endmodule

[hw/rtl/dfe_mul.sv]
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on dfe_pkg for nothing but the house import.
`timescale 1ns / 1ps

module dfe_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);
  import dfe_pkg::*;

  logic [63:0] prod_q;
  logic [63:0] prod_d;

  // One product per cycle, ready in the following cycle.
  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/dfe_iter.sv]
// Iterative square root and divider sharing one 64 bit subtract and compare.
// Depends on dfe_pkg for the operation code and the request struct.
`timescale 1ns / 1ps

module dfe_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfe_pkg::iter_req_t req_i,
  output logic               done_o,
  output logic [31:0]        res_o
);
  import dfe_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  iter_op_e    op_q, op_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] root_q, root_d;
  logic [63:0] bit_q, bit_d;
  logic [30:0] m_q, m_d;

  logic [63:0] opa, opb;
  logic [64:0] diff;
  logic        ge;
  logic [32:0] div_hi;

  // Shared compare and subtract.
  always_comb begin
    if (op_q == OP_SQRT) begin
      opa = rem_q;
      opb = root_q + bit_q;
    end else begin
      opa = {rem_q[62:0], bit_q[63]};
      opb = {33'd0, m_q};
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[64];
  end

  assign div_hi = req_i.x[63:31];

  // Start, one step per cycle, and finish.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    m_d    = m_q;
    if (req_i.start) begin
      op_d = req_i.op;
      m_d  = req_i.m;
      root_d = 64'd0;
      if (req_i.op == OP_SQRT) begin
        rem_d  = req_i.x;
        bit_d  = 64'd1 << 62;
        cnt_d  = 5'd31;
        busy_d = 1'b1;
      end else if (div_hi >= {2'b0, req_i.m}) begin
        // Quotient of 2^31 or more: clamp to 2^31 at once.
        root_d = 64'd1 << 31;
        done_d = 1'b1;
      end else begin
        rem_d  = {31'd0, div_hi};
        bit_d  = {req_i.x[30:0], 33'd0};
        cnt_d  = 5'd30;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (op_q == OP_SQRT) begin
        if (ge) begin
          rem_d  = diff[63:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        rem_d  = ge ? diff[63:0] : opa;
        root_d = {root_q[62:0], ge};
        bit_d  = bit_q << 1;
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_SQRT;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    m_q    <= m_d;
  end

  assign done_o = done_q;
  assign res_o  = root_q[31:0];

endmodule

[verif/testbench.sv]
// Self-checking testbench of the drag fall Euler step unit.
// Depends on dfe_pkg and drag_fall_euler_step_unit; predicts each result in place.
`timescale 1ns / 1ps

module testbench;
  import dfe_pkg::*;

  // Word 0..8: pos x/y/z, vel x/y/z, acc x/y/z; word 9 holds the flag in bit 0.
  typedef logic [0:9][31:0] point_state_t;

  typedef struct packed {
    logic [1:0]       req;
    logic [0:5][31:0] load;
    logic             typed;
    point_state_t     state;
  } stim_row_t;

  localparam int NUM_ROWS   = 16;
  localparam int EXTREME_AT = 10;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic signed [31:0] load_pos_x_i, load_pos_y_i, load_pos_z_i;
  logic signed [31:0] load_vel_x_i, load_vel_y_i, load_vel_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [31:0] vel_x_o, vel_y_o, vel_z_o;
  logic signed [31:0] acc_x_o, acc_y_o, acc_z_o;
  logic               saturated_o;

  drag_fall_euler_step_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .load_pos_x_i (load_pos_x_i),
    .load_pos_y_i (load_pos_y_i),
    .load_pos_z_i (load_pos_z_i),
    .load_vel_x_i (load_vel_x_i),
    .load_vel_y_i (load_vel_y_i),
    .load_vel_z_i (load_vel_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .vel_x_o      (vel_x_o),
    .vel_y_o      (vel_y_o),
    .vel_z_o      (vel_z_o),
    .acc_x_o      (acc_x_o),
    .acc_y_o      (acc_y_o),
    .acc_z_o      (acc_z_o),
    .saturated_o  (saturated_o)
  );

  // Model copy of the point and of the registers.
  longint      pt_pos [3];
  longint      pt_vel [3];
  longint      pt_acc [3];
  bit [63:0]   r_mass, r_gravity, r_drag, r_dt;
  longint      r_wind [3];

  point_state_t pending_states [$];
  int           fail_count;
  bit           hold_request;
  int           burst_left;
  stim_row_t    rows [NUM_ROWS];

  string field_names [10] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                              "acc_x", "acc_y", "acc_z", "saturated"};

  // Clock and run limit.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(64'd8 * 64'd4000000);
    $display("Verification failed");
    $finish;
  end

  // Fixed point helpers.
  function automatic bit [63:0] abs64(longint x);
    return (x < 0) ? (64'd0 - x) : x;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    bit [63:0] m;
    m = (abs64(a) * abs64(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip32(longint x, inout bit flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic bit [63:0] root_floor(bit [63:0] x);
    bit [63:0] rem, root, bitv;
    rem = x;
    root = 0;
    for (int i = 0; i < 32; i++) begin
      bitv = 64'd1 << (62 - 2 * i);
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
    end
    return root;
  endfunction

  // Applies one item to the model point and returns the state it shows.
  function automatic point_state_t advance_point(logic [1:0] req, logic [0:5][31:0] load);
    point_state_t res;
    longint       v0 [3];
    longint       force_v [3];
    bit [63:0]    sum_sq, norm, k, m, q;
    longint       a;
    bit           sat;
    sat = 1'b0;
    if (req == REQ_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        pt_pos[i] = longint'($signed(load[i]));
        pt_vel[i] = longint'($signed(load[3 + i]));
      end
    end else if (req == REQ_STEP || req == REQ_STEP_WIND) begin
      m = (r_mass != 0) ? r_mass : 64'd1;
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
        v0[i] = pt_vel[i];
        sum_sq += abs64(v0[i]) * abs64(v0[i]);
      end
      norm = root_floor(sum_sq);
      k = (r_drag * norm) >> 16;
      if (k > 64'h7FFF_FFFF) begin
        k = 64'h7FFF_FFFF;
        sat = 1'b1;
      end
      for (int i = 0; i < 3; i++) force_v[i] = -q_mul(longint'(k), v0[i]);
      force_v[2] -= longint'((r_mass * r_gravity) >> 16);
      for (int i = 0; i < 3; i++) begin
        q = (abs64(force_v[i]) << 16) / m;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        a = (force_v[i] < 0) ? -longint'(q) : longint'(q);
        pt_acc[i] = clip32(a, sat);
      end
      for (int i = 0; i < 3; i++) begin
        pt_vel[i] = clip32(v0[i] + q_mul(pt_acc[i], longint'(r_dt)), sat);
        pt_pos[i] = clip32(pt_pos[i] + q_mul(v0[i], longint'(r_dt))
                           + ((req == REQ_STEP_WIND) ? r_wind[i] : 0), sat);
      end
    end
    for (int i = 0; i < 3; i++) begin
      res[i]     = pt_pos[i][31:0];
      res[3 + i] = pt_vel[i][31:0];
      res[6 + i] = pt_acc[i][31:0];
    end
    res[9] = {31'd0, sat};
    return res;
  endfunction

  // Output checker: each accepted item against the oldest expectation.
  always @(posedge clk_i) begin
    point_state_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o,
             acc_x_o, acc_y_o, acc_z_o, {31'd0, saturated_o}};
      if (pending_states.size() == 0) begin
        $error("unexpected item on the output channel");
        fail_count++;
      end else begin
        want = pending_states.pop_front();
        for (int i = 0; i < 10; i++) begin
          if (got[i] !== want[i]) begin
            $error("%s: expected %0h, actual %0h", field_names[i], want[i], got[i]);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus a long hold on request.
  initial begin
    int mode_left, stall_pct;
    mode_left = 0;
    stall_pct = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (800) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(400, 40);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 60;
            default: stall_pct = 95;
          endcase
        end
        mode_left--;
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Sender: offers one item, taking a random gap between bursts, and waits until taken.
  task automatic offer_item(logic [1:0] req, logic [0:5][31:0] load, bit typed,
                            point_state_t typed_state);
    point_state_t predicted;
    int           gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    load_pos_x_i <= load[0];
    load_pos_y_i <= load[1];
    load_pos_z_i <= load[2];
    load_vel_x_i <= load[3];
    load_vel_y_i <= load[4];
    load_vel_z_i <= load[5];
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_point(req, load);
    pending_states.push_back(typed ? typed_state : predicted);
  endtask

  // Waits until every expected item has come and the block has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_states.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all seven registers while the block is idle.
  task automatic write_regs(logic [0:6][31:0] vals);
    for (int i = 0; i < 7; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[2:0];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    r_mass    = {33'd0, vals[REG_MASS][30:0]};
    r_gravity = {33'd0, vals[REG_GRAVITY][30:0]};
    r_drag    = {33'd0, vals[REG_DRAG_COEF][30:0]};
    r_dt      = {33'd0, vals[REG_TIME_STEP][30:0]};
    r_wind[0] = longint'($signed(vals[REG_WIND_X]));
    r_wind[1] = longint'($signed(vals[REG_WIND_Y]));
    r_wind[2] = longint'($signed(vals[REG_WIND_Z]));
  endtask

  // Random value shaped towards small magnitudes, extremes or any pattern.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $urandom_range(20'hFFFFF);
      3: return -$urandom_range(20'hFFFFF);
      default: return $signed($urandom_range(24'hFFFFFF)) - 32'sd8388608;
    endcase
  endfunction

  function automatic logic [31:0] pick_unsigned(int low_bits);
    case ($urandom_range(4))
      0: return $urandom() & 32'h7FFF_FFFF;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range((32'd1 << low_bits) - 1);
    endcase
  endfunction

  // Main sequence.
  initial begin
    logic [0:5][31:0] load;
    logic [0:6][31:0] regs;
    logic [1:0]       req;
    int               pick;
    fail_count   = 0;
    hold_request = 1'b0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_LOAD;
    load_pos_x_i = '0;
    load_pos_y_i = '0;
    load_pos_z_i = '0;
    load_vel_x_i = '0;
    load_vel_y_i = '0;
    load_vel_z_i = '0;
    r_mass = 65536;
    r_gravity = 642252;
    r_drag = 0;
    r_dt = 655;
    for (int i = 0; i < 3; i++) begin
      pt_pos[i] = 0;
      pt_vel[i] = 0;
      pt_acc[i] = 0;
      r_wind[i] = 0;
    end

    // Directed rows: unknown code after reset, loads of the extremes, steps at
    // the reset settings, then steps with every register at an extreme.
    rows[0]  = '{2'd3, '0, 1'b1, '0};
    rows[1]  = '{REQ_STEP, '0, 1'b0, '0};
    rows[2]  = '{REQ_LOAD, {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1,
                 {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'd0, 32'd0, -32'sd642252, 32'd0}};
    rows[3]  = '{REQ_STEP, '0, 1'b0, '0};
    rows[4]  = '{REQ_LOAD, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0};
    rows[5]  = '{REQ_STEP_WIND, '0, 1'b0, '0};
    rows[6]  = '{REQ_LOAD, {32'h0001_0000, 32'hFFFF_0000, 32'd0,
                            32'h0002_0000, 32'hFFFE_0000, 32'h0010_0000}, 1'b0, '0};
    rows[7]  = '{REQ_STEP, '0, 1'b0, '0};
    rows[8]  = '{REQ_STEP_WIND, '0, 1'b0, '0};
    rows[9]  = '{2'd3, '0, 1'b0, '0};
    rows[10] = '{REQ_LOAD, {32'd0, 32'd0, 32'd0,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0};
    rows[11] = '{REQ_STEP, '0, 1'b0, '0};
    rows[12] = '{REQ_STEP_WIND, '0, 1'b0, '0};
    rows[13] = '{REQ_LOAD, '0, 1'b0, '0};
    rows[14] = '{REQ_STEP_WIND, '0, 1'b0, '0};
    rows[15] = '{2'd3, '0, 1'b0, '0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (r == EXTREME_AT) begin
        // Smallest mass, largest gravity, drag and step, wind at both ends.
        wait_idle();
        write_regs({32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
      end
      offer_item(rows[r].req, rows[r].load, rows[r].typed, rows[r].state);
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: regs = {32'd65536, 32'd642252, 32'd0, 32'd655, 32'd0, 32'd0, 32'd0};
        1: regs = {32'd0, 32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1};
        default: begin
          regs[REG_MASS]      = ($urandom_range(2) == 0) ? pick_unsigned(24)
                                                         : $urandom_range(32'h40000, 32'h4000);
          regs[REG_GRAVITY]   = pick_unsigned(22);
          regs[REG_DRAG_COEF] = ($urandom_range(1) == 0) ? pick_unsigned(31)
                                                         : $urandom_range(16'hFFFF);
          regs[REG_TIME_STEP] = ($urandom_range(3) == 0) ? pick_unsigned(31)
                                                         : $urandom_range(16'hFFFF, 1);
          regs[REG_WIND_X]    = pick_value();
          regs[REG_WIND_Y]    = pick_value();
          regs[REG_WIND_Z]    = pick_value();
        end
      endcase
      write_regs(regs);
      if (ph == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause once per phase until the block has delivered everything.
        if (n == PHASE_ITEMS / 2) wait_idle();
        pick = $urandom_range(99);
        if (pick < 12) req = REQ_LOAD;
        else if (pick < 55) req = REQ_STEP;
        else if (pick < 95) req = REQ_STEP_WIND;
        else req = 2'd3;
        for (int i = 0; i < 6; i++) load[i] = pick_value();
        offer_item(req, load, 1'b0, '0);
      end
    end

    // Drain and give the verdict.
    wait_idle();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_states.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
